// ----- rtl/ccd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants for the CAN identifier census and dispatch block.
// ----------------------------------------------------------------------------
package ccd_pkg;

    localparam int CCD_SCAN_DEPTH   = 32;
    localparam int CCD_DEVICE_SLOTS = 4;

    localparam int ID_W     = 29;
    localparam int SID_W    = 11;
    localparam int IDX_W    = 5;
    localparam int MASK_W   = 4;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 29;
    localparam int SLOTS_USED_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SLOTS_USED = 3'd4;

    typedef enum logic [1:0] {
        REQ_FRAME      = 2'd0,
        REQ_SCAN_START = 2'd1,
        REQ_SCAN_STOP  = 2'd2,
        REQ_READ       = 2'd3
    } t_req;

    // classified request handed from the front to the back
    typedef struct packed {
        t_req              req;
        logic [ID_W-1:0]   id;
        logic              ext;
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
    } t_task;

    // one census entry as stored in memory
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             ext;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage : ccd_pkg
`default_nettype wire

// ----- rtl/ccd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : ccd_ram
`default_nettype wire

// ----- rtl/ccd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module ccd_queue
    import ccd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_task i_task,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_task      o_head
);

    t_task      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule : ccd_queue
`default_nettype wire

// ----- rtl/ccd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_front
// Holds the dispatch slot registers, accepts requests, normalizes the frame
// identifier and computes the slot match mask.
// ----------------------------------------------------------------------------
module ccd_front
    import ccd_pkg::*;
#(
    parameter int DEVICE_SLOTS = CCD_DEVICE_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [ID_W-1:0]       i_frame_id,
    input  wire logic                  i_frame_ext,
    input  wire logic [IDX_W-1:0]      i_entry_index,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_task                      o_task
);

    localparam int SLOT_LIM = (DEVICE_SLOTS < MASK_W) ? DEVICE_SLOTS : MASK_W;

    logic [ID_W-1:0]         r_dev_id [MASK_W];
    logic [SLOTS_USED_W-1:0] r_slots_used;

    logic [ID_W-1:0]         id_norm;
    logic [SLOTS_USED_W-1:0] used;
    logic [MASK_W-1:0]       mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MASK_W; i++) begin
                r_dev_id[i] <= '0;
            end
            r_slots_used <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ID_0:       r_dev_id[0] <= i_cfg_data[ID_W-1:0];
                CFG_DEVICE_ID_1:       r_dev_id[1] <= i_cfg_data[ID_W-1:0];
                CFG_DEVICE_ID_2:       r_dev_id[2] <= i_cfg_data[ID_W-1:0];
                CFG_DEVICE_ID_3:       r_dev_id[3] <= i_cfg_data[ID_W-1:0];
                CFG_DEVICE_SLOTS_USED: r_slots_used <= i_cfg_data[SLOTS_USED_W-1:0];
                default: ;
            endcase
        end
    end

    // standard frames carry only an 11-bit identifier
    assign id_norm = i_frame_ext ? i_frame_id : {{(ID_W-SID_W){1'b0}}, i_frame_id[SID_W-1:0]};

    assign used = (r_slots_used > SLOTS_USED_W'(SLOT_LIM)) ?
                  SLOTS_USED_W'(SLOT_LIM) : r_slots_used;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            mask[i] = (SLOTS_USED_W'(i) < used) && (r_dev_id[i] == id_norm);
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_task.req  = t_req'(i_req_type);
        o_task.id   = id_norm;
        o_task.ext  = i_frame_ext;
        o_task.idx  = i_entry_index;
        o_task.mask = mask;
    end

endmodule : ccd_front
`default_nettype wire

// ----- rtl/ccd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_back
// Carries out classified requests: frame counters, the census walk over the
// table memory, scan control and entry reads, and holds the result register.
// ----------------------------------------------------------------------------
module ccd_back
    import ccd_pkg::*;
#(
    parameter int SCAN_DEPTH = CCD_SCAN_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire t_task              i_q_head,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [MASK_W-1:0]       o_match_mask,
    output logic [CNT_W-1:0]        o_total_frames,
    output logic [CNT_W-1:0]        o_dispatched_frames,
    output logic [SLOT_W-1:0]       o_census_slot,
    output logic [CNT_W-1:0]        o_census_hits,
    output logic [SLOT_W-1:0]       o_census_used,
    output logic                    o_scan_running,
    output logic                    o_read_valid,
    output logic [ID_W-1:0]         o_read_id,
    output logic                    o_read_ext,
    output logic [CNT_W-1:0]        o_read_count
);

    localparam int AW   = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
    localparam int FW   = $clog2(SCAN_DEPTH + 1);
    localparam int CMPW = (FW > IDX_W) ? FW : IDX_W;
    localparam int EW   = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_READ
    } t_state;

    t_state           r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic             r_scan, n_scan;
    logic [CNT_W-1:0] r_frame_total, n_frame_total;
    logic [CNT_W-1:0] r_disp_total, n_disp_total;
    logic [FW-1:0]    r_issue, n_issue;
    logic [AW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_cmp_vld, n_cmp_vld;
    t_task            r_task, n_task;

    logic              r_out_valid, n_out_valid;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [FW-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]  r_hits, n_hits;
    logic              r_rvalid, n_rvalid;
    t_entry            r_rentry, n_rentry;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    t_entry        rd_entry;

    logic          out_free;
    logic          hit;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] fill_ext;

    ccd_ram #(
        .WIDTH (EW),
        .DEPTH (SCAN_DEPTH)
    ) u_census_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = r_cmp_vld && (rd_entry.id == r_task.id) && (rd_entry.ext == r_task.ext);
    assign idx_ext  = CMPW'(i_q_head.idx);
    assign fill_ext = CMPW'(r_fill);

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_scan        = r_scan;
        n_frame_total = r_frame_total;
        n_disp_total  = r_disp_total;
        n_issue       = r_issue;
        n_cmp_idx     = r_cmp_idx;
        n_cmp_vld     = r_cmp_vld;
        n_task        = r_task;
        n_out_valid   = r_out_valid && i_out_stall;
        n_mask        = r_mask;
        n_slot        = r_slot;
        n_hits        = r_hits;
        n_rvalid      = r_rvalid;
        n_rentry      = r_rentry;
        o_q_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_cmp_idx;
        ram_wdata     = rd_entry;
        ram_re        = 1'b0;
        ram_raddr     = r_issue[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop  = 1'b1;
                    n_task   = i_q_head;
                    // defaults of a finished result, overridden below
                    n_mask   = '0;
                    n_slot   = FW'(SCAN_DEPTH);
                    n_hits   = '0;
                    n_rvalid = 1'b0;
                    n_rentry = '0;
                    case (i_q_head.req)
                        REQ_FRAME: begin
                            n_frame_total = r_frame_total + 1'b1;
                            if (i_q_head.mask != '0) begin
                                n_disp_total = r_disp_total + 1'b1;
                            end
                            n_mask = i_q_head.mask;
                            if (r_scan) begin
                                n_state   = S_WALK;
                                n_issue   = '0;
                                n_cmp_vld = 1'b0;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        REQ_SCAN_START: begin
                            n_fill      = '0;
                            n_scan      = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        REQ_SCAN_STOP: begin
                            n_scan      = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        REQ_READ: begin
                            if (idx_ext < fill_ext) begin
                                ram_re    = 1'b1;
                                ram_raddr = idx_ext[AW-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_WALK: begin
                if (hit) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_cmp_idx;
                    ram_wdata.id    = rd_entry.id;
                    ram_wdata.ext   = rd_entry.ext;
                    ram_wdata.count = rd_entry.count + 1'b1;
                    n_slot          = FW'(r_cmp_idx);
                    n_hits          = rd_entry.count + 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end else if (r_issue < r_fill) begin
                    // one entry read per cycle, compared the cycle after
                    ram_re    = 1'b1;
                    ram_raddr = r_issue[AW-1:0];
                    n_cmp_idx = r_issue[AW-1:0];
                    n_cmp_vld = 1'b1;
                    n_issue   = r_issue + 1'b1;
                end else begin
                    // pair not present: append unless the table is full
                    if (r_fill < FW'(SCAN_DEPTH)) begin
                        ram_we          = 1'b1;
                        ram_waddr       = r_fill[AW-1:0];
                        ram_wdata.id    = r_task.id;
                        ram_wdata.ext   = r_task.ext;
                        ram_wdata.count = CNT_W'(1);
                        n_slot          = r_fill;
                        n_hits          = CNT_W'(1);
                        n_fill          = r_fill + 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_READ: begin
                n_rvalid    = 1'b1;
                n_rentry    = rd_entry;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_task    <= n_task;
        r_mask    <= n_mask;
        r_slot    <= n_slot;
        r_hits    <= n_hits;
        r_rvalid  <= n_rvalid;
        r_rentry  <= n_rentry;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fill        <= '0;
            r_scan        <= 1'b0;
            r_frame_total <= '0;
            r_disp_total  <= '0;
            r_cmp_vld     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_fill        <= n_fill;
            r_scan        <= n_scan;
            r_frame_total <= n_frame_total;
            r_disp_total  <= n_disp_total;
            r_cmp_vld     <= n_cmp_vld;
            r_out_valid   <= n_out_valid;
        end
    end

    // status fields follow the live registers, which only change once this
    // result has been handed over
    assign o_out_valid         = r_out_valid;
    assign o_match_mask        = r_mask;
    assign o_total_frames      = r_frame_total;
    assign o_dispatched_frames = r_disp_total;
    assign o_census_slot       = SLOT_W'(r_slot);
    assign o_census_hits       = r_hits;
    assign o_census_used       = SLOT_W'(r_fill);
    assign o_scan_running      = r_scan;
    assign o_read_valid        = r_rvalid;
    assign o_read_id           = r_rentry.id;
    assign o_read_ext          = r_rentry.ext;
    assign o_read_count        = r_rentry.count;

endmodule : ccd_back
`default_nettype wire

// ----- rtl/can_id_census_and_dispatch.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// can_id_census_and_dispatch
// CAN frame identity census and device dispatch: counts frames, matches
// identifiers against the dispatch slots and keeps a census of distinct ids.
//
//   channel   signals                              direction   transfer when
//   request   i_in_valid / o_in_stall + fields     in          valid && !stall
//   result    o_out_valid / i_out_stall + fields   out         valid && !stall
//   config    i_cfg_we / i_cfg_idx / i_cfg_data    in          i_cfg_we
//
// While scanning, the back end walks the census table for each frame, reading
// one census entry per cycle from the table memory and stopping early on a
// hit. Results are held in a result register; a two-entry queue lets the
// front keep taking requests while the back works or the result is stalled,
// until the queue is full.
// Reset is synchronous; no clearing pass runs, the table is tracked by fill.
// ----------------------------------------------------------------------------
module can_id_census_and_dispatch
    import ccd_pkg::*;
#(
    parameter int SCAN_DEPTH   = CCD_SCAN_DEPTH,
    parameter int DEVICE_SLOTS = CCD_DEVICE_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [ID_W-1:0]       i_frame_id,
    input  wire logic                  i_frame_ext,
    input  wire logic [IDX_W-1:0]      i_entry_index,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [MASK_W-1:0]          o_match_mask,
    output logic [CNT_W-1:0]           o_total_frames,
    output logic [CNT_W-1:0]           o_dispatched_frames,
    output logic [SLOT_W-1:0]          o_census_slot,
    output logic [CNT_W-1:0]           o_census_hits,
    output logic [SLOT_W-1:0]          o_census_used,
    output logic                       o_scan_running,
    output logic                       o_read_valid,
    output logic [ID_W-1:0]            o_read_id,
    output logic                       o_read_ext,
    output logic [CNT_W-1:0]           o_read_count
);

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_task q_in;
    t_task q_head;

    ccd_front #(
        .DEVICE_SLOTS (DEVICE_SLOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_frame_id    (i_frame_id),
        .i_frame_ext   (i_frame_ext),
        .i_entry_index (i_entry_index),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_task        (q_in)
    );

    ccd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    ccd_back #(
        .SCAN_DEPTH (SCAN_DEPTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (q_empty),
        .i_q_head            (q_head),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_match_mask        (o_match_mask),
        .o_total_frames      (o_total_frames),
        .o_dispatched_frames (o_dispatched_frames),
        .o_census_slot       (o_census_slot),
        .o_census_hits       (o_census_hits),
        .o_census_used       (o_census_used),
        .o_scan_running      (o_scan_running),
        .o_read_valid        (o_read_valid),
        .o_read_id           (o_read_id),
        .o_read_ext          (o_read_ext),
        .o_read_count        (o_read_count)
    );

endmodule : can_id_census_and_dispatch
`default_nettype wire
